FILE: rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor controller.
// No dependencies; imported by every module of the block.
package tcc_pkg;

  localparam int COORD_BITS = 13;               // cursor column / pixel row width
  localparam int CELL_BITS  = 12;               // scaled cell size (7b x 5b)
  localparam int PROD_BITS  = COORD_BITS + CELL_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLYPH_SCALE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_W     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_H     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCROLL_MODE  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BG_COLOR     = 3'd6;

  // register reset values
  localparam logic [6:0]            GW_RST   = 7'd8;
  localparam logic [6:0]            GH_RST   = 7'd16;
  localparam logic [4:0]            GS_RST   = 5'd1;
  localparam logic [COORD_BITS-1:0] SW_RST   = 13'd1024;
  localparam logic [COORD_BITS-1:0] SH_RST   = 13'd768;
  localparam logic [COORD_BITS-1:0] MODE_RST = 13'd0;
  localparam logic [CFG_DATA_BITS-1:0] NO_FILL = 32'hFF00_0000;

  // character codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_NEL   = 8'h85;

  // result kinds
  localparam logic [1:0] K_RENDER = 2'd0;
  localparam logic [1:0] K_SCROLL = 2'd1;
  localparam logic [1:0] K_WIPE   = 2'd2;
  localparam logic [1:0] K_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP, OP_CR, OP_BS, OP_NEL, OP_LF, OP_VT, OP_TAB, OP_CLEAR, OP_PRINT
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RENDER, B_NL, B_CLEAR, B_FLUSH
  } bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] glyph;
  } cmd_t;

  typedef struct packed {
    logic [CELL_BITS-1:0]  cw;     // scaled cell width
    logic [CELL_BITS-1:0]  ch;     // scaled cell height
    logic [COORD_BITS-1:0] sw;
    logic [COORD_BITS-1:0] sh;
    logic [COORD_BITS-1:0] mode;
    logic                  fill;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            glyph;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] line_top;
    logic [COORD_BITS-1:0] rows;
    logic [COORD_BITS-1:0] step;
    logic                  fill;
    logic                  last;
  } res_t;

endpackage

FILE: rtl/tcc_front.sv
// Front end: takes input bytes, classifies them into commands and queues them.
// Depends on tcc_pkg.
module tcc_front
  import tcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  output logic       cmd_valid,
  input  logic       cmd_pop,
  output cmd_t       cmd
);

  cmd_t                 q_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  op_t                  op_dec;
  logic                 push, pop;

  always_comb begin
    unique case (in_tdata) inside
      CH_ESC, CH_DEL, CH_BEL: op_dec = OP_NOP;
      CH_NEL:                 op_dec = OP_NEL;
      CH_FF:                  op_dec = OP_CLEAR;
      CH_BS:                  op_dec = OP_BS;
      CH_CR:                  op_dec = OP_CR;
      CH_VT:                  op_dec = OP_VT;
      CH_LF:                  op_dec = OP_LF;
      CH_TAB:                 op_dec = OP_TAB;
      default:                op_dec = OP_PRINT;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_BITS'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_dec, glyph: in_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QDEPTH))
    else $error("queue count over depth");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count not reduced on pop");
  a_empty_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && push) |=> (cmd_valid && cmd.op == $past(op_dec)))
    else $error("queued command lost");
`endif

endmodule

FILE: rtl/tcc_back.sv
// Back end: sequencer that carries out queued commands, keeps cursor state
// and drives the result channel through a pending stage and output register.
// Depends on tcc_pkg.
module tcc_back
  import tcc_pkg::*;
#(
  parameter int TAB_SPACES = 8,
  parameter int VTAB_LINES = 6
)(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int REP_MAX  = (TAB_SPACES > VTAB_LINES) ? TAB_SPACES : VTAB_LINES;
  localparam int REP_BITS = $clog2(REP_MAX + 1);

  bstate_t               state_r, state_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt, top_r, top_nxt;
  logic [REP_BITS-1:0]   rep_r, rep_nxt;
  logic [7:0]            glyph_r, glyph_nxt;
  logic                  is_glyph_r, is_glyph_nxt;
  res_t                  pend_r, pend_nxt, out_r, out_nxt, new_res;
  logic                  pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;

  logic                  out_free, emit, stall, rep_done;
  logic [COORD_BITS-1:0] col_inc;
  logic [PROD_BITS-1:0]  prod;
  logic [COORD_BITS:0]   x_lim;
  logic                  crossed;
  logic signed [15:0]    sl_s;
  logic                  no_scroll;
  logic [COORD_BITS-1:0] sl_sat, nt, top_plus;
  logic [COORD_BITS:0]   nt_s;
  logic                  mode_is_ch, mode_is_h, mode_zero;

  // wrap test for the column after a glyph
  assign col_inc = col_r + 1'b1;
  assign prod    = {{CELL_BITS{1'b0}}, col_inc} * {{COORD_BITS{1'b0}}, cfg.cw};
  assign x_lim   = {1'b0, cfg.sw} - {2'b00, cfg.cw};
  assign crossed = x_lim[COORD_BITS] ||
                   (prod > {{(PROD_BITS-COORD_BITS){1'b0}}, x_lim[COORD_BITS-1:0]});

  // newline arithmetic: overflow amount, saturated scroll and new top
  assign sl_s      = $signed({3'b000, top_r}) + $signed({3'b000, cfg.ch, 1'b0})
                   - $signed({3'b000, cfg.sh});
  assign no_scroll = sl_s[15] || (sl_s == '0);
  assign sl_sat    = (sl_s[14:13] != 2'b00) ? '1 : sl_s[COORD_BITS-1:0];
  assign nt_s      = {1'b0, cfg.sh} - {2'b00, cfg.ch};
  assign nt        = nt_s[COORD_BITS] ? '0 : nt_s[COORD_BITS-1:0];
  assign top_plus  = top_r + {1'b0, cfg.ch};
  assign mode_zero  = (cfg.mode == '0);
  assign mode_is_ch = (cfg.mode == {1'b0, cfg.ch});
  assign mode_is_h  = (cfg.mode == cfg.sh);

  assign out_free = !out_v_r || out_tready;
  assign rep_done = (rep_r == REP_BITS'(1));

  always_comb begin
    new_res = '0;
    emit    = 1'b0;
    unique case (state_r)
      B_RENDER: begin
        emit           = 1'b1;
        new_res.kind   = K_RENDER;
        new_res.glyph  = glyph_r;
        new_res.column = col_r;
        new_res.line_top = top_r;
      end
      B_CLEAR: begin
        emit           = 1'b1;
        new_res.kind   = K_CLEAR;
        new_res.column = col_r;
        new_res.line_top = top_r;
      end
      B_NL: begin
        emit           = !no_scroll && !mode_zero;
        new_res.column = col_r;
        new_res.fill   = cfg.fill;
        if (mode_is_ch) begin
          new_res.kind     = K_SCROLL;
          new_res.line_top = nt;
          new_res.rows     = sl_sat;
          new_res.step     = sl_sat;
        end else if (mode_is_h) begin
          new_res.kind     = K_WIPE;
        end else begin
          new_res.kind     = K_SCROLL;
          new_res.line_top = nt;
          new_res.rows     = sl_sat;
          new_res.step     = cfg.mode;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    stall = (emit && pend_v_r && !out_free) ||
            (state_r == B_FLUSH && pend_v_r && !out_free);
  end

  assign cmd_pop = (state_r == B_IDLE) && cmd_valid;

  // sequencer: next state, cursor state and result staging
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    rep_nxt      = rep_r;
    glyph_nxt    = glyph_r;
    is_glyph_nxt = is_glyph_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r && !out_tready;

    if (!stall) begin
      if (emit) begin
        pend_nxt   = new_res;
        pend_v_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b0;
          out_v_nxt    = 1'b1;
        end
      end

      unique case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_CR: col_nxt = '0;
              OP_BS: begin
                if (col_r != '0) col_nxt = col_r - 1'b1;
              end
              OP_NEL: begin
                col_nxt      = '0;
                rep_nxt      = REP_BITS'(1);
                is_glyph_nxt = 1'b0;
                state_nxt    = B_NL;
              end
              OP_LF: begin
                rep_nxt      = REP_BITS'(1);
                is_glyph_nxt = 1'b0;
                state_nxt    = B_NL;
              end
              OP_VT: begin
                rep_nxt      = REP_BITS'(VTAB_LINES);
                is_glyph_nxt = 1'b0;
                state_nxt    = B_NL;
              end
              OP_TAB: begin
                rep_nxt      = REP_BITS'(TAB_SPACES);
                glyph_nxt    = CH_SPACE;
                is_glyph_nxt = 1'b1;
                state_nxt    = B_RENDER;
              end
              OP_PRINT: begin
                rep_nxt      = REP_BITS'(1);
                glyph_nxt    = cmd.glyph;
                is_glyph_nxt = 1'b1;
                state_nxt    = B_RENDER;
              end
              OP_CLEAR: state_nxt = B_CLEAR;
              default:  state_nxt = B_IDLE;   // ignored codes
            endcase
          end
        end
        B_RENDER: begin
          if (crossed) begin
            col_nxt   = '0;
            state_nxt = B_NL;               // rep counted down after the newline
          end else begin
            col_nxt = col_inc;
            if (rep_done) state_nxt = B_FLUSH;
            else          rep_nxt   = rep_r - 1'b1;
          end
        end
        B_NL: begin
          if (no_scroll)                    top_nxt = top_plus;
          else if (mode_zero || (!mode_is_ch && mode_is_h)) top_nxt = '0;
          else                              top_nxt = nt;
          if (rep_done) begin
            state_nxt = B_FLUSH;
          end else begin
            rep_nxt = rep_r - 1'b1;
            if (is_glyph_r) state_nxt = B_RENDER;
          end
        end
        B_CLEAR: state_nxt = B_FLUSH;
        B_FLUSH: begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
            out_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          state_nxt = B_IDLE;
        end
        default: state_nxt = B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      col_r      <= '0;
      top_r      <= '0;
      rep_r      <= '0;
      is_glyph_r <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      top_r      <= top_nxt;
      rep_r      <= rep_nxt;
      is_glyph_r <= is_glyph_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'b000, out_r.fill, out_r.step, out_r.rows,
                       out_r.line_top, out_r.column, out_r.glyph};

`ifndef SYNTH
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> !pend_v_r)
    else $error("pending result left behind at end of item");
  a_rep_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RENDER || state_r == B_NL) |-> (rep_r != '0))
    else $error("repeat count exhausted while busy");
  a_wipe_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == K_WIPE) |-> (out_r.line_top == '0 && out_r.rows == '0))
    else $error("wipe result with nonzero top or rows");
  a_render_nofill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == K_RENDER) |-> (!out_r.fill && out_r.step == '0))
    else $error("render result with scroll fields set");
`endif

endmodule

FILE: rtl/text_console_cursor_control.sv
// Top level of the text console cursor controller: configuration registers,
// front end (tcc_front) and back end (tcc_back). Depends on tcc_pkg.
//
// Usage:
//  - in_*  : one character byte per transfer (in_tdata[7:0]).
//  - out_* : render / scroll / wipe / clear commands; out_tuser is the kind,
//            out_tlast marks the final command caused by one input byte.
//  - cfg_* : register writes (index 0..6), always ready; write only while
//            the block is idle. Index 7 is ignored.
//  Flow: a printable byte passes the command queue, the sequencer state, the
//  pending stage and the output register. Unless the output stalls, the back
//  end runs one step per cycle: ignored codes, CR and backspace take the idle
//  step alone; a printed byte, LF, form feed, VT or tab add a render, newline
//  or clear step per glyph or line, a newline step on each wrap, and a flush.
//  The sequencer sets the item rate; a two-entry queue takes input meanwhile.
//  Reset: cursor column and line top go to 0, registers to their defaults,
//  both queues empty. No clearing pass.
//  Stall: when out_tready is low the output register holds its command and
//  the sequencer waits; the queue fills, then in_tready drops.
module text_console_cursor_control
  import tcc_pkg::*;
#(
  parameter int TAB_SPACES = 8,   // 1..16
  parameter int VTAB_LINES = 6    // 1..16
)(
  input  logic                     clk,
  input  logic                     rst_n,
  // input byte channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,    // [7:0] char_code
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [63:0]              out_tdata,   // [7:0] glyph, [20:8] column,
                                                // [33:21] line_top, [46:34] scroll_rows,
                                                // [59:47] scroll_step, [60] fill_background,
                                                // [63:61] zero
  output logic [1:0]               out_tuser,   // [1:0] kind
  output logic                     out_tlast,   // last
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [6:0]            gw_r, gh_r;
  logic [4:0]            gs_r;
  logic [COORD_BITS-1:0] sw_r, sh_r, mode_r;
  logic                  fill_r;
  logic [CELL_BITS-1:0]  cw_r, ch_r;
  cfg_t                  cfg;
  cmd_t                  cmd;
  logic                  cmd_valid, cmd_pop;

  assign cfg_ready = 1'b1;

  // register file; background color kept only as its fill flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= GW_RST;
      gh_r   <= GH_RST;
      gs_r   <= GS_RST;
      sw_r   <= SW_RST;
      sh_r   <= SH_RST;
      mode_r <= MODE_RST;
      fill_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:  gw_r   <= cfg_data[6:0];
        REG_GLYPH_HEIGHT: gh_r   <= cfg_data[6:0];
        REG_GLYPH_SCALE:  gs_r   <= cfg_data[4:0];
        REG_SCREEN_W:     sw_r   <= cfg_data[COORD_BITS-1:0];
        REG_SCREEN_H:     sh_r   <= cfg_data[COORD_BITS-1:0];
        REG_SCROLL_MODE:  mode_r <= cfg_data[COORD_BITS-1:0];
        REG_BG_COLOR:     fill_r <= (cfg_data != NO_FILL);
        default:          ;
      endcase
    end
  end

  // scaled cell size, registered from the glyph size and scale registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= CELL_BITS'(GW_RST);
      ch_r <= CELL_BITS'(GH_RST);
    end else begin
      cw_r <= {5'b0, gw_r} * {7'b0, gs_r};
      ch_r <= {5'b0, gh_r} * {7'b0, gs_r};
    end
  end

  assign cfg = '{cw: cw_r, ch: ch_r, sw: sw_r, sh: sh_r, mode: mode_r, fill: fill_r};

  tcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  tcc_back #(
    .TAB_SPACES (TAB_SPACES),
    .VTAB_LINES (VTAB_LINES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/text_console_cursor_control_tb.sv
// Self-checking testbench for text_console_cursor_control: drives bytes and register
// writes, predicts every render/scroll/wipe/clear command and checks each result transfer.
// Depends on tcc_pkg and the RTL top level only.
module text_console_cursor_control_tb;
  import tcc_pkg::*;

  localparam int    TAB_SPACES     = 8;
  localparam int    VTAB_LINES     = 6;
  localparam longint COORD_MAX     = (64'd1 << COORD_BITS) - 1;
  localparam int    DRAIN_CYCLES   = 64;    // worst no-result backlog is well under this
  localparam int    WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;  // index past the register file

  // one expected command, fields at the block's widths
  typedef struct {
    bit [1:0]            kind;
    bit [7:0]            glyph;
    bit [COORD_BITS-1:0] column;
    bit [COORD_BITS-1:0] line_top;
    bit [COORD_BITS-1:0] rows;
    bit [COORD_BITS-1:0] step;
    bit                  fill;
    bit                  last;
  } console_cmd_t;

  // Cursor/scroll predictor plus the queue of commands still owed by the block.
  class console_scoreboard;
    bit [6:0]            gw, gh;
    bit [4:0]            gs;
    bit [COORD_BITS-1:0] sw, sh, mode;
    bit [31:0]           bg;
    bit [COORD_BITS-1:0] col, top;
    console_cmd_t        owed_cmds[$];
    int                  errors;

    function new();
      gw = GW_RST; gh = GH_RST; gs = GS_RST;
      sw = SW_RST; sh = SH_RST; mode = MODE_RST; bg = NO_FILL;
      col = '0; top = '0; errors = 0;
    endfunction

    function int pending();
      return owed_cmds.size();
    endfunction

    function void write_reg(bit [CFG_IDX_BITS-1:0] idx, bit [31:0] data);
      case (idx)
        REG_GLYPH_WIDTH:  gw   = data[6:0];
        REG_GLYPH_HEIGHT: gh   = data[6:0];
        REG_GLYPH_SCALE:  gs   = data[4:0];
        REG_SCREEN_W:     sw   = data[COORD_BITS-1:0];
        REG_SCREEN_H:     sh   = data[COORD_BITS-1:0];
        REG_SCROLL_MODE:  mode = data[COORD_BITS-1:0];
        REG_BG_COLOR:     bg   = data;
        default: ;
      endcase
    endfunction

    // column/line_top always reflect the cursor at the time of the command
    function void push_cmd(bit [1:0] kind, bit [7:0] glyph, bit [COORD_BITS-1:0] rows,
                           bit [COORD_BITS-1:0] step, bit fill);
      console_cmd_t c;
      c.kind = kind; c.glyph = glyph; c.column = col; c.line_top = top;
      c.rows = rows; c.step = step; c.fill = fill; c.last = 1'b0;
      owed_cmds.push_back(c);
    endfunction

    function void line_feed();
      longint ch, t, h, m, sl, nt;
      bit     fill;
      ch   = longint'(gh) * longint'(gs);
      t    = longint'(top);
      h    = longint'(sh);
      m    = longint'(mode);
      fill = (bg != NO_FILL);
      if (t + ch <= h - ch) begin
        top = COORD_BITS'(t + ch);
        return;
      end
      if (m == 0) begin
        top = '0;   // wrap to top, silent
        return;
      end
      sl = t + 2 * ch - h;
      if (sl > COORD_MAX) sl = COORD_MAX;
      if (sl < 0) sl = 0;
      nt = h - ch;
      if (nt < 0) nt = 0;
      if (nt > COORD_MAX) nt = COORD_MAX;
      if (m == ch) begin
        top = COORD_BITS'(nt);
        push_cmd(K_SCROLL, 8'h00, COORD_BITS'(sl), COORD_BITS'(sl), fill);
      end else if (m == h) begin
        top = '0;
        push_cmd(K_WIPE, 8'h00, '0, '0, fill);
      end else begin
        top = COORD_BITS'(nt);
        push_cmd(K_SCROLL, 8'h00, COORD_BITS'(sl), mode, fill);
      end
    endfunction

    function void print_glyph(bit [7:0] g);
      longint cw;
      cw = longint'(gw) * longint'(gs);
      push_cmd(K_RENDER, g, '0, '0, 1'b0);
      col = col + 1'b1;
      // negative right edge (cell wider than screen) always wraps
      if (longint'(col) * cw > longint'(sw) - cw) begin
        col = '0;
        line_feed();
      end
    endfunction

    function void note_char(bit [7:0] code);
      int           n0;
      console_cmd_t tail;
      n0 = owed_cmds.size();
      case (code)
        CH_ESC, CH_DEL, CH_BEL: ;
        CH_NEL: begin
          col = '0;
          line_feed();
        end
        CH_FF:  push_cmd(K_CLEAR, 8'h00, '0, '0, 1'b0);
        CH_BS:  if (col != 0) col = col - 1'b1;
        CH_CR:  col = '0;
        CH_VT:  repeat (VTAB_LINES) line_feed();
        CH_LF:  line_feed();
        CH_TAB: repeat (TAB_SPACES) print_glyph(CH_SPACE);
        default: print_glyph(code);
      endcase
      if (owed_cmds.size() > n0) begin
        tail = owed_cmds.pop_back();
        tail.last = 1'b1;
        owed_cmds.push_back(tail);
      end
    endfunction

    function void field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(bit [63:0] data, bit [1:0] kind, bit last);
      console_cmd_t e;
      if (owed_cmds.size() == 0) begin
        $error("result with nothing owed: kind %0d data %h last %0d", kind, data, last);
        errors++;
        return;
      end
      e = owed_cmds.pop_front();
      field("kind",            e.kind,     kind);
      field("glyph",           e.glyph,    data[7:0]);
      field("column",          e.column,   data[20:8]);
      field("line_top",        e.line_top, data[33:21]);
      field("scroll_rows",     e.rows,     data[46:34]);
      field("scroll_step",     e.step,     data[59:47]);
      field("fill_background", e.fill,     data[60]);
      field("tdata_pad",       0,          data[63:61]);
      field("last",            e.last,     last);
    endfunction
  endclass

  // DUT signals; the inputs are at known values from time 0
  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = 8'h00;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [63:0]              out_tdata;
  logic [1:0]               out_tuser;
  logic                     out_tlast;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

  console_scoreboard sb;
  int idle_pct  = 0;   // chance the sender skips a cycle
  int stall_pct = 0;   // chance the receiver drops tready
  int quiet_cycles = 0;

  bit [7:0] opening_chars[16] = '{8'h41, 8'h00, 8'hFF, CH_BS, CH_BS, CH_BS, CH_BS, CH_TAB,
                                  CH_CR, CH_NEL, CH_LF, CH_VT, CH_FF, CH_ESC, CH_DEL, CH_BEL};
  bit [7:0] control_codes[10] = '{CH_TAB, CH_LF, CH_VT, CH_CR, CH_BS,
                                  CH_NEL, CH_FF, CH_ESC, CH_DEL, CH_BEL};

  text_console_cursor_control #(
    .TAB_SPACES (TAB_SPACES),
    .VTAB_LINES (VTAB_LINES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure, applied on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker and watchdog; sampling on the rising edge sees pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no transfer for %0d cycles, %0d commands owed",
               quiet_cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sender: one byte per call, random idle cycles ahead of it; tvalid stays
  // high into the next call when that call does not idle
  task automatic send_char(input bit [7:0] code);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(code);
  endtask

  task automatic cfg_write(input bit [CFG_IDX_BITS-1:0] idx, input bit [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // let everything owed come out, then the silent tail of the pipeline
  // (CR, backspace, silent newlines) settle before touching registers
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit [31:0] gw, gh, gs, sw, sh, mode, bg);
    drain();
    cfg_write(REG_GLYPH_WIDTH,  gw);
    cfg_write(REG_GLYPH_HEIGHT, gh);
    cfg_write(REG_GLYPH_SCALE,  gs);
    cfg_write(REG_SCREEN_W,     sw);
    cfg_write(REG_SCREEN_H,     sh);
    cfg_write(REG_SCROLL_MODE,  mode);
    cfg_write(REG_BG_COLOR,     bg);
    cfg_write(REG_UNUSED,       $urandom);   // must be ignored
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 88; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 88; end
      default: begin idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  // mostly text and control codes, the rest any byte
  function automatic bit [7:0] random_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(126, 32));
    if (r < 65) return control_codes[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: reset geometry, every code, backspace at column 0
    foreach (opening_chars[i]) send_char(opening_chars[i]);

    // 4x4 cell screen, smooth scroll with fill: tab wraps twice, VT scrolls
    configure(8, 8, 1, 32, 32, 8, 32'h0011_2233);
    send_char(CH_TAB);
    send_char(CH_VT);
    // wipe mode
    configure(8, 8, 1, 32, 32, 32, NO_FILL);
    send_char(CH_VT);
    send_char(CH_LF);
    // stepped scroll
    configure(8, 8, 1, 32, 32, 3, 32'h0000_0000);
    send_char(CH_VT);
    // wrap to top, no result
    configure(8, 8, 1, 32, 32, 0, NO_FILL);
    send_char(CH_VT);
    send_char(CH_NEL);
    // cell bigger than the screen: every glyph and line crosses the edge
    configure(64, 64, 16, 100, 100, 1, NO_FILL);
    send_char(8'h78);
    send_char(CH_LF);

    // --- random phases, each with its own geometry and idling pattern
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(8, 8, 1, 40, 40, 8, 32'h0011_2233);          // smooth, fill
        1: configure(3, 5, 2, 50, 47, 47, NO_FILL);                // wipe
        2: configure(6, 4, 3, 61, 70, 5, $urandom);                // stepped
        3: configure(5, 7, 1, 30, 30, 0, 0);                       // wrap to top
        4: configure($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);                // raw register bits
        5: configure(127, 127, 31, 8191, 8191, 8191, 32'hFFFF_FFFF);
        6: configure(0, 0, 0, 0, 0, 0, 0);                         // all-zero geometry
        default: configure(2, 3, 4, 24, 36, 12, NO_FILL);          // smooth, no fill
      endcase
      set_idling(p % 4);
      repeat (12) send_char(random_char());
    end

    // --- zero cell width: no wrap, column keeps counting up
    set_idling(0);
    configure(0, 16, 1, 100, 100, 0, NO_FILL);
    repeat (4) send_char(CH_TAB);

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
